### rtl/normalized_line_convolution_macros.svh
// Assertion helpers for the line convolution checker
`ifndef NORMALIZED_LINE_CONVOLUTION_MACROS_SVH
`define NORMALIZED_LINE_CONVOLUTION_MACROS_SVH

// same-cycle implication, sampled on clk, off during reset
`define NLC_ASSERT_NOW(label, ante, cons) \
  label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
    else $error("normalized_line_convolution: check failed");

// next-cycle implication
`define NLC_ASSERT_NEXT(label, ante, cons) \
  label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
    else $error("normalized_line_convolution: check failed");

`endif

### rtl/nlc_pkg.sv
package nlc_pkg;

  localparam int SAMPLE_WIDTH = 16;
  localparam int WEIGHT_WIDTH = 16;
  localparam int HALF_LIMIT   = 6;
  localparam int HW_W         = 3;
  localparam int CFG_IDX_W    = 3;
  localparam int CFG_DATA_W   = 16;
  localparam int NUM_WEIGHTS  = 7;

  localparam logic [CFG_IDX_W-1:0] REG_HALF_WIDTH    = 3'd0;
  localparam logic [CFG_IDX_W-1:0] REG_CENTRE_WEIGHT = 3'd1;
  localparam logic [CFG_IDX_W-1:0] REG_WEIGHT_ONE    = 3'd2;
  localparam logic [CFG_IDX_W-1:0] REG_WEIGHT_TWO    = 3'd3;
  localparam logic [CFG_IDX_W-1:0] REG_WEIGHT_THREE  = 3'd4;
  localparam logic [CFG_IDX_W-1:0] REG_WEIGHT_FOUR   = 3'd5;
  localparam logic [CFG_IDX_W-1:0] REG_WEIGHT_FIVE   = 3'd6;
  localparam logic [CFG_IDX_W-1:0] REG_WEIGHT_SIX    = 3'd7;

  typedef struct packed {
    logic signed [SAMPLE_WIDTH-1:0] sample;
    logic                           sample_valid;
    logic                           last_in_line;
  } in_item_t;

  typedef struct packed {
    logic signed [SAMPLE_WIDTH-1:0] smoothed;
    logic                           smoothed_valid;
    logic                           last_of_line;
  } out_item_t;

  typedef struct packed {
    logic shift;
    logic clear;
  } cell_ctrl_t;

  typedef enum logic [2:0] {
    S_IDLE,
    S_DECIDE,
    S_SUM,
    S_DIV,
    S_OUT
  } state_t;

endpackage

### rtl/nlc_cell.sv
module nlc_cell #(
  parameter int ACC_W  = 37,
  parameter int NORM_W = 20
) (
  input  logic                                    clk,
  input  logic                                    rst_n,
  input  nlc_pkg::cell_ctrl_t                     ctrl,
  input  logic signed [nlc_pkg::SAMPLE_WIDTH-1:0] samp_in,
  input  logic                                    flag_in,
  input  logic [nlc_pkg::WEIGHT_WIDTH-1:0]        weight,
  input  logic                                    tap_en,
  input  logic signed [ACC_W-1:0]                 acc_in,
  input  logic [NORM_W-1:0]                       norm_in,
  input  logic                                    any_in,
  output logic signed [nlc_pkg::SAMPLE_WIDTH-1:0] samp_out,
  output logic                                    flag_out,
  output logic signed [ACC_W-1:0]                 acc_out,
  output logic [NORM_W-1:0]                       norm_out,
  output logic                                    any_out
);

  localparam int PROD_W = nlc_pkg::SAMPLE_WIDTH + nlc_pkg::WEIGHT_WIDTH + 1;

  logic signed [nlc_pkg::SAMPLE_WIDTH-1:0] samp_r;
  logic                                    flag_r;
  logic signed [PROD_W-1:0]                prod_r;
  logic [nlc_pkg::WEIGHT_WIDTH-1:0]        wt_r;
  logic                                    use_r;
  logic signed [ACC_W-1:0]                 acc_r;
  logic [NORM_W-1:0]                       norm_r;
  logic                                    any_r;
  logic signed [nlc_pkg::WEIGHT_WIDTH:0]   weight_s;
  logic                                    use_nxt;

  assign weight_s = $signed({1'b0, weight});
  assign use_nxt  = flag_r & tap_en;

  // window tap
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      flag_r <= 1'b0;
    end else if (ctrl.clear) begin
      flag_r <= 1'b0;
    end else if (ctrl.shift) begin
      flag_r <= flag_in;
    end
  end

  always_ff @(posedge clk) begin
    if (ctrl.clear) begin
      samp_r <= '0;
    end else if (ctrl.shift) begin
      samp_r <= samp_in;
    end
  end

  // product stage, then the running sums ripple one cell per cycle
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      use_r <= 1'b0;
      any_r <= 1'b0;
    end else begin
      use_r <= use_nxt;
      any_r <= any_in | use_r;
    end
  end

  always_ff @(posedge clk) begin
    prod_r <= use_nxt ? PROD_W'(samp_r * weight_s) : '0;
    wt_r   <= use_nxt ? weight : '0;
    acc_r  <= acc_in + ACC_W'(prod_r);
    norm_r <= norm_in + NORM_W'(wt_r);
  end

  assign samp_out = samp_r;
  assign flag_out = flag_r;
  assign acc_out  = acc_r;
  assign norm_out = norm_r;
  assign any_out  = any_r;

endmodule

### rtl/nlc_div.sv
module nlc_div #(
  parameter int DVD_W = 37,
  parameter int DVS_W = 20
) (
  input  logic             clk,
  input  logic             rst_n,
  input  logic             start,
  input  logic [DVD_W-1:0] dividend,
  input  logic [DVS_W-1:0] divisor,
  output logic [DVD_W-1:0] quotient,
  output logic             done
);

  localparam int CNT_W = $clog2(DVD_W + 1);

  logic [DVD_W-1:0] quo_r;
  logic [DVS_W-1:0] rem_r;
  logic [DVS_W-1:0] dvs_r;
  logic [CNT_W-1:0] cnt_r;
  logic             busy_r;
  logic             done_r;
  logic [DVS_W:0]   rem_sh;
  logic [DVS_W+1:0] diff;
  logic             fits;

  // restoring division, one quotient bit per cycle
  assign rem_sh = {rem_r, quo_r[DVD_W-1]};
  assign diff   = {1'b0, rem_sh} - {2'b00, dvs_r};
  assign fits   = ~diff[DVS_W+1];

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      busy_r <= 1'b0;
      done_r <= 1'b0;
      cnt_r  <= '0;
    end else if (start) begin
      busy_r <= 1'b1;
      done_r <= 1'b0;
      cnt_r  <= '0;
    end else if (busy_r) begin
      cnt_r <= cnt_r + 1'b1;
      if (cnt_r == CNT_W'(DVD_W - 1)) begin
        busy_r <= 1'b0;
        done_r <= 1'b1;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (start) begin
      quo_r <= dividend;
      rem_r <= '0;
      dvs_r <= divisor;
    end else if (busy_r) begin
      quo_r <= {quo_r[DVD_W-2:0], fits};
      rem_r <= fits ? diff[DVS_W-1:0] : rem_sh[DVS_W-1:0];
    end
  end

  assign quotient = quo_r;
  assign done     = done_r;

endmodule

### rtl/normalized_line_convolution.sv
// Normalized convolution along one axis. Samples shift through a row of
// 2*MAX_HALF_WIDTH+1 tap cells, one cell per line position. The block works on
// one input transfer at a time: a transfer that yields a result passes the
// accept state, the decide state, the sum state while the weighted sums ripple
// down the cell row, the bit-serial divider and the output state, held for any
// output stall, before the next transfer can be accepted. A transfer that
// yields no result passes only the accept and decide states. The transfer
// flagged last_in_line then steps through half_width more positions, each
// through the decide state and, when it yields a result, the sum state, the
// divider and the output state. Results are the weighted mean of the valid
// taps, truncated toward zero and saturated; smoothed_valid is low when no
// tap inside the line was valid.
module normalized_line_convolution #(
  parameter int MAX_HALF_WIDTH = 6
) (
  input  logic                                clk,
  input  logic                                rst_n,
  input  logic                                in_valid,
  output logic                                in_stall,
  input  nlc_pkg::in_item_t                   in_data,
  output logic                                out_valid,
  input  logic                                out_stall,
  output nlc_pkg::out_item_t                  out_data,
  input  logic                                cfg_we,
  input  logic [nlc_pkg::CFG_IDX_W-1:0]       cfg_idx,
  input  logic [nlc_pkg::CFG_DATA_W-1:0]      cfg_wdata
);

  localparam int SW      = nlc_pkg::SAMPLE_WIDTH;
  localparam int WW      = nlc_pkg::WEIGHT_WIDTH;
  localparam int DEPTH   = 2 * MAX_HALF_WIDTH + 1;
  localparam int PROD_W  = SW + WW + 1;
  localparam int ACC_W   = PROD_W + $clog2(DEPTH);
  localparam int NORM_W  = WW + $clog2(DEPTH);
  localparam int HW_LIM  = (MAX_HALF_WIDTH < nlc_pkg::HALF_LIMIT) ?
                           MAX_HALF_WIDTH : nlc_pkg::HALF_LIMIT;
  localparam int IDX_W   = $clog2(DEPTH);
  localparam int CW      = ((IDX_W > 3) ? IDX_W : 3) + 1;
  localparam int FILL_W  = $clog2(DEPTH + 1);
  localparam int FCW     = ((FILL_W > 3) ? FILL_W : 3) + 1;
  localparam int CNT_W   = $clog2(DEPTH + 1);
  localparam logic signed [ACC_W:0] SAT_HI = {{(ACC_W - SW + 2){1'b0}}, {(SW - 1){1'b1}}};
  localparam logic signed [ACC_W:0] SAT_LO = ~SAT_HI;

  // configuration
  logic [nlc_pkg::HW_W-1:0] hw_r;
  logic [WW-1:0]            wgt_r [nlc_pkg::NUM_WEIGHTS];
  logic [nlc_pkg::HW_W-1:0] h_eff;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      hw_r <= '0;
      for (int i = 0; i < nlc_pkg::NUM_WEIGHTS; i++) begin
        wgt_r[i] <= (i == 0) ? {WW{1'b1}} : '0;
      end
    end else if (cfg_we) begin
      unique case (cfg_idx) inside
        nlc_pkg::REG_HALF_WIDTH: hw_r <= cfg_wdata[nlc_pkg::HW_W-1:0];
        nlc_pkg::REG_CENTRE_WEIGHT, nlc_pkg::REG_WEIGHT_ONE, nlc_pkg::REG_WEIGHT_TWO,
        nlc_pkg::REG_WEIGHT_THREE, nlc_pkg::REG_WEIGHT_FOUR, nlc_pkg::REG_WEIGHT_FIVE,
        nlc_pkg::REG_WEIGHT_SIX:
          wgt_r[cfg_idx - nlc_pkg::REG_CENTRE_WEIGHT] <= cfg_wdata[WW-1:0];
        default: ;
      endcase
    end
  end

  assign h_eff = (hw_r > nlc_pkg::HW_W'(HW_LIM)) ? nlc_pkg::HW_W'(HW_LIM) : hw_r;

  // control
  nlc_pkg::state_t     state_r, state_nxt;
  logic [FILL_W-1:0]   fill_r, fill_nxt;
  logic [nlc_pkg::HW_W-1:0] j_r, j_nxt;
  logic                last_r, last_nxt;
  logic [CNT_W-1:0]    cnt_r, cnt_nxt;
  nlc_pkg::cell_ctrl_t cctl;
  logic                inject_zero;
  logic                div_start;
  logic                div_done;
  logic                emit;
  logic                adv;
  logic                load_out;
  logic [FCW-1:0]      fill_ext;

  assign fill_ext = FCW'(fill_r) + (last_r ? FCW'(j_r) : '0);
  assign emit     = fill_ext > FCW'(h_eff);

  always_comb begin
    state_nxt   = state_r;
    fill_nxt    = fill_r;
    j_nxt       = j_r;
    last_nxt    = last_r;
    cnt_nxt     = cnt_r;
    cctl        = '0;
    inject_zero = 1'b0;
    div_start   = 1'b0;
    adv         = 1'b0;
    load_out    = 1'b0;
    unique case (state_r)
      nlc_pkg::S_IDLE: begin
        if (in_valid) begin
          cctl.shift = 1'b1;
          fill_nxt   = (fill_r == FILL_W'(DEPTH)) ? fill_r : fill_r + 1'b1;
          last_nxt   = in_data.last_in_line;
          j_nxt      = '0;
          state_nxt  = nlc_pkg::S_DECIDE;
        end
      end
      nlc_pkg::S_DECIDE: begin
        if (emit) begin
          cnt_nxt   = '0;
          state_nxt = nlc_pkg::S_SUM;
        end else begin
          adv = 1'b1;
        end
      end
      nlc_pkg::S_SUM: begin
        cnt_nxt = cnt_r + 1'b1;
        // tail cell holds the full sum once the products have rippled through
        if (cnt_r == CNT_W'(DEPTH)) begin
          div_start = 1'b1;
          state_nxt = nlc_pkg::S_DIV;
        end
      end
      nlc_pkg::S_DIV: begin
        if (div_done) begin
          load_out  = 1'b1;
          state_nxt = nlc_pkg::S_OUT;
        end
      end
      nlc_pkg::S_OUT: begin
        if (!out_stall) begin
          adv = 1'b1;
        end
      end
      default: state_nxt = nlc_pkg::S_IDLE;
    endcase

    // step to the next line position: done, flush one more, or end the line
    if (adv) begin
      if (!last_r) begin
        state_nxt = nlc_pkg::S_IDLE;
      end else if (j_r == h_eff) begin
        cctl.clear = 1'b1;
        fill_nxt   = '0;
        state_nxt  = nlc_pkg::S_IDLE;
      end else begin
        cctl.shift  = 1'b1;
        inject_zero = 1'b1;
        j_nxt       = j_r + 1'b1;
        state_nxt   = nlc_pkg::S_DECIDE;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r <= nlc_pkg::S_IDLE;
      fill_r  <= '0;
      j_r     <= '0;
      last_r  <= 1'b0;
      cnt_r   <= '0;
    end else begin
      state_r <= state_nxt;
      fill_r  <= fill_nxt;
      j_r     <= j_nxt;
      last_r  <= last_nxt;
      cnt_r   <= cnt_nxt;
    end
  end

  // tap cell row
  logic signed [SW-1:0]     c_samp_in  [DEPTH];
  logic                     c_flag_in  [DEPTH];
  logic signed [ACC_W-1:0]  c_acc_in   [DEPTH];
  logic [NORM_W-1:0]        c_norm_in  [DEPTH];
  logic                     c_any_in   [DEPTH];
  logic signed [SW-1:0]     c_samp     [DEPTH];
  logic                     c_flag     [DEPTH];
  logic signed [ACC_W-1:0]  c_acc      [DEPTH];
  logic [NORM_W-1:0]        c_norm     [DEPTH];
  logic                     c_any      [DEPTH];
  logic [WW-1:0]            c_wgt      [DEPTH];
  logic                     c_en       [DEPTH];

  for (genvar k = 0; k < DEPTH; k++) begin : g_cell
    logic [CW-1:0] kc;
    logic [CW-1:0] hc;
    logic [CW-1:0] tap_dist;

    assign kc       = CW'(k);
    assign hc       = CW'(h_eff);
    assign tap_dist = (kc > hc) ? (kc - hc) : (hc - kc);
    assign c_en[k]  = kc <= (hc << 1);
    assign c_wgt[k] = c_en[k] ? wgt_r[tap_dist[2:0]] : '0;

    if (k == 0) begin : g_head
      assign c_samp_in[k] = inject_zero ? '0 : in_data.sample;
      assign c_flag_in[k] = inject_zero ? 1'b0 : in_data.sample_valid;
      assign c_acc_in[k]  = '0;
      assign c_norm_in[k] = '0;
      assign c_any_in[k]  = 1'b0;
    end else begin : g_link
      assign c_samp_in[k] = c_samp[k-1];
      assign c_flag_in[k] = c_flag[k-1];
      assign c_acc_in[k]  = c_acc[k-1];
      assign c_norm_in[k] = c_norm[k-1];
      assign c_any_in[k]  = c_any[k-1];
    end

    nlc_cell #(
      .ACC_W  (ACC_W),
      .NORM_W (NORM_W)
    ) u_cell (
      .clk      (clk),
      .rst_n    (rst_n),
      .ctrl     (cctl),
      .samp_in  (c_samp_in[k]),
      .flag_in  (c_flag_in[k]),
      .weight   (c_wgt[k]),
      .tap_en   (c_en[k]),
      .acc_in   (c_acc_in[k]),
      .norm_in  (c_norm_in[k]),
      .any_in   (c_any_in[k]),
      .samp_out (c_samp[k]),
      .flag_out (c_flag[k]),
      .acc_out  (c_acc[k]),
      .norm_out (c_norm[k]),
      .any_out  (c_any[k])
    );
  end

  // division of |acc| by the weight sum
  logic signed [ACC_W-1:0] acc_tail;
  logic [ACC_W-1:0]        acc_mag;
  logic signed [ACC_W-1:0] acc_hold_r;
  logic                    neg_r;
  logic                    normz_r;
  logic                    any_r;
  logic [ACC_W-1:0]        quo;

  assign acc_tail = c_acc[DEPTH-1];
  assign acc_mag  = acc_tail[ACC_W-1] ? ACC_W'(-acc_tail) : ACC_W'(acc_tail);

  always_ff @(posedge clk) begin
    if (div_start) begin
      acc_hold_r <= acc_tail;
      neg_r      <= acc_tail[ACC_W-1];
      normz_r    <= (c_norm[DEPTH-1] == '0);
      any_r      <= c_any[DEPTH-1];
    end
  end

  nlc_div #(
    .DVD_W (ACC_W),
    .DVS_W (NORM_W)
  ) u_div (
    .clk      (clk),
    .rst_n    (rst_n),
    .start    (div_start),
    .dividend (acc_mag),
    .divisor  (c_norm[DEPTH-1]),
    .quotient (quo),
    .done     (div_done)
  );

  // sign, saturate, register the result
  logic signed [ACC_W:0] q_s;
  logic signed [ACC_W:0] res_w;
  logic signed [SW-1:0]  res_sat;
  nlc_pkg::out_item_t    out_r;

  always_comb begin
    q_s   = neg_r ? -$signed({1'b0, quo}) : $signed({1'b0, quo});
    res_w = normz_r ? (ACC_W + 1)'(acc_hold_r) : q_s;
    if (res_w > SAT_HI) begin
      res_sat = SAT_HI[SW-1:0];
    end else if (res_w < SAT_LO) begin
      res_sat = SAT_LO[SW-1:0];
    end else begin
      res_sat = res_w[SW-1:0];
    end
  end

  always_ff @(posedge clk) begin
    if (load_out) begin
      out_r.smoothed       <= any_r ? res_sat : '0;
      out_r.smoothed_valid <= any_r;
      out_r.last_of_line   <= last_r && (j_r == h_eff);
    end
  end

  assign in_stall  = (state_r != nlc_pkg::S_IDLE);
  assign out_valid = (state_r == nlc_pkg::S_OUT);
  assign out_data  = out_r;

endmodule

### rtl/nlc_checker.sv
`include "normalized_line_convolution_macros.svh"

module nlc_checker (
  input logic               clk,
  input logic               rst_n,
  input logic               in_valid,
  input logic               in_stall,
  input logic               out_valid,
  input logic               out_stall,
  input nlc_pkg::out_item_t out_data
);

  // a held result keeps its value until taken
  `NLC_ASSERT_NEXT(a_out_hold, out_valid && out_stall, out_valid && $stable(out_data))

  // one item in flight: an accepted transfer closes the input side
  `NLC_ASSERT_NEXT(a_busy_after_accept, in_valid && !in_stall, in_stall)

  // no new input while a result is pending
  `NLC_ASSERT_NOW(a_no_accept_with_result, out_valid, in_stall)

  // an invalid result carries a zero value
  `NLC_ASSERT_NOW(a_invalid_is_zero, out_valid && !out_data.smoothed_valid,
                  out_data.smoothed == '0)

endmodule

bind normalized_line_convolution nlc_checker u_nlc_checker (
  .clk       (clk),
  .rst_n     (rst_n),
  .in_valid  (in_valid),
  .in_stall  (in_stall),
  .out_valid (out_valid),
  .out_stall (out_stall),
  .out_data  (out_data)
);

### tb/normalized_line_convolution_test.sv
`timescale 1ns / 1ps

module normalized_line_convolution_test;

  localparam int WIN_DEPTH     = 2 * nlc_pkg::HALF_LIMIT + 1;
  localparam int RANDOM_ITEMS  = 210;
  localparam int SETTLE_CYCLES = 2 * nlc_pkg::HALF_LIMIT + 60;
  localparam int CYCLE_LIMIT   = 500000;
  localparam longint SAT_HI    = (longint'(1) <<< (nlc_pkg::SAMPLE_WIDTH - 1)) - 1;
  localparam longint SAT_LO    = -SAT_HI - 1;

  localparam logic [nlc_pkg::CFG_IDX_W-1:0] WEIGHT_REGS [nlc_pkg::NUM_WEIGHTS] = '{
    nlc_pkg::REG_CENTRE_WEIGHT, nlc_pkg::REG_WEIGHT_ONE, nlc_pkg::REG_WEIGHT_TWO,
    nlc_pkg::REG_WEIGHT_THREE, nlc_pkg::REG_WEIGHT_FOUR, nlc_pkg::REG_WEIGHT_FIVE,
    nlc_pkg::REG_WEIGHT_SIX
  };

  typedef struct packed {
    logic [nlc_pkg::HW_W-1:0]                                    hw;
    logic [nlc_pkg::NUM_WEIGHTS-1:0][nlc_pkg::WEIGHT_WIDTH-1:0]  w;   // w[0] is the centre tap
  } tap_set_t;

  typedef struct {
    int                 setting;   // preset to load before this row, -1 keeps the current one
    nlc_pkg::in_item_t  item;
    bit                 typed;
    nlc_pkg::out_item_t want;
  } drill_t;

  logic clk = 1'b0;
  logic rst_n = 1'b0;
  logic in_valid = 1'b0;
  logic in_stall;
  nlc_pkg::in_item_t in_data = '0;
  logic out_valid;
  logic out_stall = 1'b0;
  nlc_pkg::out_item_t out_data;
  logic cfg_we = 1'b0;
  logic [nlc_pkg::CFG_IDX_W-1:0] cfg_idx = '0;
  logic [nlc_pkg::CFG_DATA_W-1:0] cfg_wdata = '0;

  always #2 clk = ~clk;

  normalized_line_convolution dut (
    .clk       (clk),
    .rst_n     (rst_n),
    .in_valid  (in_valid),
    .in_stall  (in_stall),
    .in_data   (in_data),
    .out_valid (out_valid),
    .out_stall (out_stall),
    .out_data  (out_data),
    .cfg_we    (cfg_we),
    .cfg_idx   (cfg_idx),
    .cfg_wdata (cfg_wdata)
  );

  // shadow of the block: registers, tap row and line position
  logic [nlc_pkg::HW_W-1:0]                hw_reg = '0;
  logic [nlc_pkg::WEIGHT_WIDTH-1:0]        tap_weight [nlc_pkg::NUM_WEIGHTS];
  logic signed [nlc_pkg::SAMPLE_WIDTH-1:0] tap_val [WIN_DEPTH];
  logic                                    tap_ok [WIN_DEPTH];
  int                                      line_fill = 0;

  nlc_pkg::out_item_t fresh_means[$];
  nlc_pkg::out_item_t pending_means[$];

  bit          quiet = 1'b0;
  int unsigned errors = 0;
  int unsigned items_sent = 0;
  int unsigned lines_sent = 0;
  int unsigned results_seen = 0;
  int unsigned settings_used = 0;
  int          cycle_count = 0;

  function automatic void flag_error(input string msg);
    errors++;
    if (errors <= 10) $display("%t ERROR %s", $realtime, msg);
  endfunction

  function automatic void roll_in(input logic signed [nlc_pkg::SAMPLE_WIDTH-1:0] s,
                                  input logic ok);
    for (int k = WIN_DEPTH - 1; k > 0; k--) begin
      tap_val[k] = tap_val[k-1];
      tap_ok[k]  = tap_ok[k-1];
    end
    tap_val[0] = s;
    tap_ok[0]  = ok;
  endfunction

  function automatic nlc_pkg::out_item_t weighted_mean(input int h, input bit closing);
    longint             acc;
    longint             norm;
    longint             res;
    int                 d;
    int                 used;
    nlc_pkg::out_item_t r;
    acc = 0;
    norm = 0;
    res = 0;
    used = 0;
    for (int k = 0; k <= 2 * h; k++) begin
      d = (k > h) ? k - h : h - k;
      if (tap_ok[k]) begin
        acc  += longint'(tap_weight[d]) * longint'(tap_val[k]);
        norm += longint'(tap_weight[d]);
        used++;
      end
    end
    if (used > 0) begin
      // all-zero weights pass the raw sum, which is zero anyway
      res = (norm != 0) ? acc / norm : acc;
      if (res > SAT_HI) res = SAT_HI;
      if (res < SAT_LO) res = SAT_LO;
    end
    r.smoothed       = res[nlc_pkg::SAMPLE_WIDTH-1:0];
    r.smoothed_valid = (used > 0);
    r.last_of_line   = closing;
    return r;
  endfunction

  function automatic void advance_line(input nlc_pkg::in_item_t it);
    int h;
    h = (int'(hw_reg) > nlc_pkg::HALF_LIMIT) ? nlc_pkg::HALF_LIMIT : int'(hw_reg);
    roll_in(it.sample, it.sample_valid);
    if (line_fill < WIN_DEPTH) line_fill++;
    if (!it.last_in_line) begin
      if (line_fill > h) fresh_means.push_back(weighted_mean(h, 1'b0));
      return;
    end
    // end of line: shift in blanks until the last position is centred
    for (int j = 0; j <= h; j++) begin
      if (j > 0) roll_in('0, 1'b0);
      if (line_fill + j > h) fresh_means.push_back(weighted_mean(h, j == h));
    end
    for (int k = 0; k < WIN_DEPTH; k++) begin
      tap_val[k] = '0;
      tap_ok[k]  = 1'b0;
    end
    line_fill = 0;
  endfunction

  task automatic send_item(input nlc_pkg::in_item_t it, input bit typed,
                           input nlc_pkg::out_item_t want);
    while (!quiet && $urandom_range(0, 99) < 6) begin
      in_valid <= 1'b0;
      @(posedge clk);
    end
    in_valid <= 1'b1;
    in_data  <= it;
    @(posedge clk);
    while (in_stall) @(posedge clk);
    advance_line(it);
    if (typed) begin
      pending_means.push_back(want);
      fresh_means.delete();
    end else begin
      while (fresh_means.size() > 0) pending_means.push_back(fresh_means.pop_front());
    end
    items_sent++;
    if (it.last_in_line) lines_sent++;
  endtask

  // drops the input only when it has to wait, so it never drives in_valid twice at once
  task automatic wait_empty();
    if (pending_means.size() != 0) begin
      in_valid <= 1'b0;
      while (pending_means.size() != 0) @(posedge clk);
    end
  endtask

  task automatic settle();
    wait_empty();
    in_valid <= 1'b0;
    repeat (SETTLE_CYCLES) @(posedge clk);
  endtask

  task automatic write_reg(input logic [nlc_pkg::CFG_IDX_W-1:0] idx,
                           input logic [nlc_pkg::CFG_DATA_W-1:0] val);
    cfg_we    <= 1'b1;
    cfg_idx   <= idx;
    cfg_wdata <= val;
    @(posedge clk);
    if (idx == nlc_pkg::REG_HALF_WIDTH) hw_reg = val[nlc_pkg::HW_W-1:0];
    else tap_weight[idx - nlc_pkg::REG_CENTRE_WEIGHT] = val;
  endtask

  task automatic apply_setting(input tap_set_t s);
    write_reg(nlc_pkg::REG_HALF_WIDTH, nlc_pkg::CFG_DATA_W'(s.hw));
    for (int i = 0; i < nlc_pkg::NUM_WEIGHTS; i++) write_reg(WEIGHT_REGS[i], s.w[i]);
    cfg_we <= 1'b0;
    settings_used++;
  endtask

  function automatic logic [nlc_pkg::WEIGHT_WIDTH-1:0] pick_weight();
    int r;
    r = $urandom_range(0, 99);
    if (r < 15) return '0;
    if (r < 30) return '1;
    return nlc_pkg::WEIGHT_WIDTH'($urandom);
  endfunction

  function automatic tap_set_t random_setting();
    tap_set_t s;
    int r;
    r = $urandom_range(0, 3);
    s.hw = (r == 0) ? '0 : (r == 1) ? '1 : nlc_pkg::HW_W'($urandom_range(1, 6));
    for (int i = 0; i < nlc_pkg::NUM_WEIGHTS; i++) s.w[i] = pick_weight();
    return s;
  endfunction

  function automatic drill_t row(input int setting, input int s, input bit v, input bit l,
                                 input bit typed = 1'b0, input int ws = 0,
                                 input bit wv = 1'b0, input bit wl = 1'b0);
    drill_t r;
    r.setting                 = setting;
    r.item.sample             = nlc_pkg::SAMPLE_WIDTH'(s);
    r.item.sample_valid       = v;
    r.item.last_in_line       = l;
    r.typed                   = typed;
    r.want.smoothed           = nlc_pkg::SAMPLE_WIDTH'(ws);
    r.want.smoothed_valid     = wv;
    r.want.last_of_line       = wl;
    return r;
  endfunction

  // result side: random stall, compare each transfer with the oldest prediction
  always @(posedge clk) begin
    nlc_pkg::out_item_t want;
    if (rst_n && out_valid && !out_stall) begin
      results_seen++;
      if (pending_means.size() == 0) begin
        flag_error($sformatf("unexpected result smoothed=%0d valid=%0b last=%0b",
                             out_data.smoothed, out_data.smoothed_valid,
                             out_data.last_of_line));
      end else begin
        want = pending_means.pop_front();
        if (out_data.smoothed !== want.smoothed ||
            out_data.smoothed_valid !== want.smoothed_valid ||
            out_data.last_of_line !== want.last_of_line) begin
          flag_error($sformatf("result %0d: want smoothed=%0d valid=%0b last=%0b, got %0d %0b %0b",
                               results_seen, want.smoothed, want.smoothed_valid,
                               want.last_of_line, out_data.smoothed,
                               out_data.smoothed_valid, out_data.last_of_line));
        end
      end
    end
    out_stall <= !quiet && ($urandom_range(0, 99) < 6);
  end

  always @(posedge clk) begin
    cycle_count <= cycle_count + 1;
    if (cycle_count > CYCLE_LIMIT) begin
      $display("timeout after %0d cycles, %0d results outstanding",
               cycle_count, pending_means.size());
      $display("FAIL normalized_line_convolution");
      $finish;
    end
  end

  initial begin
    tap_set_t          presets [3];
    drill_t            drills[$];
    nlc_pkg::in_item_t it;
    int                phase;
    int                len;
    int                flavor;
    int                hold_at;
    int                pick;

    tap_weight[0] = '1;
    for (int i = 1; i < nlc_pkg::NUM_WEIGHTS; i++) tap_weight[i] = '0;
    for (int k = 0; k < WIN_DEPTH; k++) begin
      tap_val[k] = '0;
      tap_ok[k]  = 1'b0;
    end

    presets[0].hw = nlc_pkg::HW_W'(2);
    presets[0].w  = '0;
    presets[0].w[0] = 16'd32768;
    presets[0].w[1] = 16'd16384;
    presets[0].w[2] = 16'd8192;
    // half width beyond the tap row is clamped
    presets[1].hw = '1;
    presets[1].w  = '1;
    // every weight zero
    presets[2].hw = nlc_pkg::HW_W'(3);
    presets[2].w  = '0;

    // reset values: h = 0 and full centre weight, so each sample comes back as is
    drills.push_back(row(-1, 32767, 1, 0, 1, 32767, 1, 0));
    drills.push_back(row(-1, -32768, 1, 0, 1, -32768, 1, 0));
    drills.push_back(row(-1, 0, 1, 0, 1, 0, 1, 0));
    drills.push_back(row(-1, -1, 0, 0, 1, 0, 0, 0));
    drills.push_back(row(-1, 12345, 1, 1, 1, 12345, 1, 1));
    // one-sample line shorter than the half width
    drills.push_back(row(0, 100, 1, 1));
    drills.push_back(row(-1, 1000, 1, 0));
    drills.push_back(row(-1, -2000, 0, 0));
    drills.push_back(row(-1, 30000, 1, 0));
    drills.push_back(row(-1, -32768, 1, 0));
    drills.push_back(row(-1, 5, 1, 1));
    drills.push_back(row(1, 32767, 1, 0));
    drills.push_back(row(-1, 32767, 1, 0));
    drills.push_back(row(-1, -32768, 0, 0));
    drills.push_back(row(-1, 100, 1, 0));
    drills.push_back(row(-1, -100, 1, 0));
    drills.push_back(row(-1, 0, 1, 0));
    drills.push_back(row(-1, 32767, 1, 1));
    drills.push_back(row(-1, -32768, 1, 0));
    drills.push_back(row(-1, -32768, 1, 1));
    drills.push_back(row(2, 500, 1, 0));
    drills.push_back(row(-1, -500, 1, 0));
    drills.push_back(row(-1, 0, 0, 0));
    drills.push_back(row(-1, 77, 1, 1));

    repeat (4) @(posedge clk);
    rst_n <= 1'b1;
    @(posedge clk);

    foreach (drills[i]) begin
      if (drills[i].setting >= 0) begin
        settle();
        apply_setting(presets[drills[i].setting]);
      end
      send_item(drills[i].item, drills[i].typed, drills[i].want);
    end

    phase = 0;
    while (items_sent < drills.size() + RANDOM_ITEMS) begin
      settle();
      quiet = (phase == 2);
      apply_setting(random_setting());
      repeat ($urandom_range(2, 4)) begin
        len     = ($urandom_range(0, 4) == 0) ? $urandom_range(13, 30) : $urandom_range(1, 12);
        flavor  = $urandom_range(0, 9);
        hold_at = (phase == 1 || $urandom_range(0, 9) == 0) ? $urandom_range(0, len - 1) : -1;
        for (int n = 0; n < len; n++) begin
          if (n == hold_at) wait_empty();
          if (flavor == 9 || $urandom_range(0, 7) == 0) begin
            pick = $urandom_range(0, 3);
            it.sample = (pick == 0) ? 16'sh7fff : (pick == 1) ? 16'sh8000 :
                        (pick == 2) ? 16'sh0000 : 16'shffff;
          end else begin
            it.sample = nlc_pkg::SAMPLE_WIDTH'($urandom);
          end
          // flavor 0: line with no usable sample, flavor 1: mostly invalid
          if (flavor == 0) it.sample_valid = 1'b0;
          else if (flavor == 1) it.sample_valid = ($urandom_range(0, 4) == 0);
          else it.sample_valid = ($urandom_range(0, 99) < 85);
          it.last_in_line = (n == len - 1);
          send_item(it, 1'b0, '0);
        end
      end
      phase++;
    end

    settle();
    $display("%0d samples in %0d lines over %0d register settings, %0d results checked",
             items_sent, lines_sent, settings_used + 1, results_seen);
    $display("half widths from 0 to beyond the tap row, weights from zero to full scale");
    if (errors == 0) begin
      $display("PASS normalized_line_convolution");
    end else begin
      $display("%0d mismatches", errors);
      $display("FAIL normalized_line_convolution");
    end
    $finish;
  end

endmodule

### filelist.f
+incdir+rtl
rtl/nlc_pkg.sv
rtl/nlc_cell.sv
rtl/nlc_div.sv
rtl/normalized_line_convolution.sv
rtl/nlc_checker.sv
tb/normalized_line_convolution_test.sv
